### hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    // Control codes that are not printed, and the space that fills a scrolled-in row
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BELL      = 8'h07;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam int TAB_STEP = 4;

    // Action codes
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Reset values
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CLEAR_CHAR = 8'h07;
    localparam logic [7:0] CLEAR_ATTR = 8'h00;

    localparam int POS_W = 11;

    // One screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
    } t_cell;

    // One result beat
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       rchar;
        logic [7:0]       rattr;
        logic             scrolled;
    } t_result;

endpackage

### hw/rtl/tccw_cell_ram.sv
`timescale 1ns / 1ps

module tccw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tccw_pkg::t_cell i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tccw_pkg::t_cell o_rdata
);
    import tccw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_LINES   = 25,
    parameter int AW             = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [7:0]        i_character,
    input  logic [10:0]       i_cell_index,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tccw_pkg::t_result o_out,
    // cell store
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output tccw_pkg::t_cell   o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  tccw_pkg::t_cell   i_mem_rdata
);
    import tccw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_LINES;
    localparam int CW  = $clog2(SCREEN_COLUMNS);
    localparam int LW  = $clog2(SCREEN_LINES);
    localparam int CW1 = CW + 1;
    localparam int LW1 = LW + 1;
    localparam int PW  = (AW >= POS_W) ? AW + 1 : POS_W + 1;

    localparam logic [CW:0]   COLS      = CW1'(SCREEN_COLUMNS);
    localparam logic [LW:0]   LINES     = LW1'(SCREEN_LINES);
    localparam logic [LW:0]   LAST_LINE = LW1'(SCREEN_LINES - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] BOTTOM    = AW'((SCREEN_LINES - 1) * SCREEN_COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_COLUMNS);
    localparam logic [PW-1:0] COLS_P    = PW'(SCREEN_COLUMNS);
    localparam logic [PW-1:0] CELLS_P   = PW'(CELL_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_col, n_col;
    logic [LW-1:0] r_line, n_line;
    logic [7:0]    r_attr, n_attr;
    logic          r_rd_hit, n_rd_hit;
    logic          r_wb_valid, n_wb_valid;
    logic [AW-1:0] r_wb_addr, n_wb_addr;
    logic          r_wb_bottom, n_wb_bottom;
    t_result       r_res, n_res;
    logic          r_res_valid, n_res_valid;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          res_move;
    logic          in_ready;
    logic          accept;
    logic [CW:0]   col_t;
    logic [LW:0]   line_t;
    logic          printable;
    logic          scroll_t;
    logic [PW-1:0] cur_pos;
    logic [PW-1:0] new_pos;
    logic [PW-1:0] idx_p;
    logic          idx_hit;
    logic [AW-1:0] sweep_src;

    // Handshake: one item in work at a time, result slot must be free
    assign res_move   = r_res_valid && (!r_out_valid || !i_out_stall);
    assign in_ready   = (r_state == S_IDLE) && (!r_res_valid || res_move);
    assign accept     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // Cursor step for a put
    always_comb begin
        col_t     = {1'b0, r_col};
        line_t    = {1'b0, r_line};
        printable = 1'b0;
        scroll_t  = 1'b0;
        case (i_character)
            CH_NEWLINE: begin
                line_t = line_t + 1'b1;
                col_t  = '0;
            end
            CH_RETURN: begin
                col_t = '0;
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    col_t = col_t - 1'b1;
                end
            end
            CH_TAB: begin
                col_t = col_t + CW1'(TAB_STEP);
            end
            CH_BELL: begin
                col_t = {1'b0, r_col};
            end
            default: begin
                col_t     = col_t + 1'b1;
                printable = 1'b1;
            end
        endcase
        if (col_t >= COLS) begin
            col_t  = '0;
            line_t = line_t + 1'b1;
        end
        if (line_t >= LINES) begin
            line_t   = LAST_LINE;
            scroll_t = 1'b1;
        end
    end

    // Linear positions before and after the step
    assign cur_pos = PW'(r_col) + PW'(r_line) * COLS_P;
    assign new_pos = PW'(col_t) + PW'(line_t) * COLS_P;

    assign idx_p   = PW'(i_cell_index);
    assign idx_hit = idx_p < CELLS_P;

    // Scroll source: next row down, or the bottom row onto itself
    assign sweep_src = (r_cnt < BOTTOM) ? r_cnt + ROW_STEP : r_cnt;

    // Cell store access
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wb_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = sweep_src;
        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt;
                o_mem_wdata = '{attr: CLEAR_ATTR, chr: CLEAR_CHAR};
            end
            S_IDLE: begin
                if (accept && i_action == ACT_PUT && printable) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = cur_pos[AW-1:0];
                    o_mem_wdata = '{attr: r_attr, chr: i_character};
                end
                if (accept && i_action == ACT_READ && idx_hit) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = idx_p[AW-1:0];
                end
            end
            S_SCROLL, S_DRAIN: begin
                o_mem_we = r_wb_valid;
                if (r_wb_bottom) begin
                    o_mem_wdata = '{attr: i_mem_rdata.attr, chr: CH_SPACE};
                end
                o_mem_re = (r_state == S_SCROLL);
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_line      = r_line;
        n_attr      = i_cfg_we ? i_cfg_wdata : r_attr;
        n_rd_hit    = r_rd_hit;
        n_wb_valid  = (r_state == S_SCROLL);
        n_wb_addr   = r_cnt;
        n_wb_bottom = (r_cnt >= BOTTOM);
        n_res       = r_res;
        n_res_valid = r_res_valid && !res_move;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        // move a finished result to the output register
        if (res_move) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_action == ACT_READ) begin
                        n_rd_hit = idx_hit;
                        n_state  = S_READ;
                    end else begin
                        n_col  = col_t[CW-1:0];
                        n_line = line_t[LW-1:0];
                        if (scroll_t) begin
                            n_state = S_SCROLL;
                        end else begin
                            n_res       = '{pos: new_pos[POS_W-1:0], rchar: 8'h00,
                                            rattr: 8'h00, scrolled: 1'b0};
                            n_res_valid = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_res = '{pos: cur_pos[POS_W-1:0],
                          rchar: r_rd_hit ? i_mem_rdata.chr : 8'h00,
                          rattr: r_rd_hit ? i_mem_rdata.attr : 8'h00,
                          scrolled: 1'b0};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCROLL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_res = '{pos: cur_pos[POS_W-1:0], rchar: 8'h00,
                          rattr: 8'h00, scrolled: 1'b1};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, cursor and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_attr      <= ATTR_RESET;
            r_wb_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_line      <= n_line;
            r_attr      <= n_attr;
            r_wb_valid  <= n_wb_valid;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
        r_rd_hit    <= n_rd_hit;
        r_wb_addr   <= n_wb_addr;
        r_wb_bottom <= n_wb_bottom;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hw/rtl/text_console_char_writer.sv
`timescale 1ns / 1ps

// Text console writer: a screen of SCREEN_COLUMNS x SCREEN_LINES cells held in
// one memory with one write and one registered read port, plus a cursor. After
// reset the block sweeps the memory once to set every cell to char 7 / attr 0;
// input beats stall during that pass, attribute writes are taken at any time.
// A put that does not scroll sets its result beat when it is taken, and the
// beat passes through the result slot and the output register, so puts can
// stream at one per cycle while the output is not stalled. A read waits in a
// read state for the registered memory data, stalling the input, and its
// result takes the same path. A put that scrolls copies the screen one cell
// per cycle through the read and write ports while the input is held, then a
// drain state writes the last cell and sets the result beat. A result
// register and a one-beat result slot let the next item enter while a result
// waits to be taken.
module text_console_char_writer #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_LINES   = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_character,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_position,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    output logic        o_scrolled
);
    import tccw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_LINES;
    localparam int AW         = $clog2(CELL_COUNT);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_cell         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_cell         mem_rdata;
    t_result       out_beat;

    tccw_ctrl #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_LINES   (SCREEN_LINES),
        .AW             (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_character  (i_character),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (out_beat),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    tccw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cursor_position = out_beat.pos;
    assign o_read_char       = out_beat.rchar;
    assign o_read_attr       = out_beat.rattr;
    assign o_scrolled        = out_beat.scrolled;

`ifndef SYNTHESIS
    // The clearing pass holds off input beats right after reset
    a_clear_stalls: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // A printable put writes its cell in the cycle it is taken
    a_put_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_PUT &&
         i_character != CH_NEWLINE && i_character != CH_RETURN &&
         i_character != CH_BACKSPACE && i_character != CH_TAB &&
         i_character != CH_BELL) |-> mem_we)
        else $error("printable put did not write the cell store");

    // A read leaves the store alone while its data comes back
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_READ) |-> !mem_we ##1 !mem_we)
        else $error("cell store written during a read");

    // Never read and write one entry in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same cell");
`endif

endmodule
